// ----- rtl/tslfo_pkg.sv -----
// Package with shared types, constants and the raised-cosine travel table of the LFO sweep.
package tslfo_pkg;

    localparam int MAX_STEP   = 8;
    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;
    localparam int TABLE_N    = 1 << TABLE_BITS;

    localparam int STEP_W  = 5;
    localparam int TPB_W   = 16;
    localparam int VALUE_W = 16;
    localparam int TRAVEL_W = 17;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BAR = 1'd1;

    localparam int MAG_W  = $clog2(MAX_STEP + 1);
    localparam int NUM_W  = PHASE_BITS - 6 + MAX_STEP + 1;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef logic [TRAVEL_W-1:0] t_travel;
    typedef t_travel t_rom [TABLE_N];

    typedef struct packed {
        logic [VALUE_W-1:0]    base;
        logic [TABLE_BITS-1:0] idx;
        logic [15:0]           phase;
        logic [1:0]            dir;
    } t_entry;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    function automatic t_travel travel_calc(int unsigned i);
        int unsigned ii;
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] term;
        logic signed [64:0] sum;
        logic [63:0] sq;
        ii = (i > TABLE_N / 2) ? (TABLE_N - i) : i;
        theta = (PI_Q30 * 64'(ii)) >> TABLE_BITS;
        th2 = (theta * theta) >> 30;
        term = theta;
        sum = signed'({1'b0, theta});
        for (int k = 1; k <= 7; k++) begin
            term = (term * th2) >> 30;
            term = term / 64'(2 * k * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - signed'({1'b0, term});
            end else begin
                sum = sum + signed'({1'b0, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > signed'({1'b0, ONE_Q30})) begin
            sum = signed'({1'b0, ONE_Q30});
        end
        sq = sum[63:0] * sum[63:0];
        sq = (sq + (64'd1 << 43)) >> 44;
        return sq[TRAVEL_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int unsigned i = 0; i < TABLE_N; i++) begin
            rom[i] = travel_calc(i);
        end
        return rom;
    endfunction

    localparam t_rom TRAVEL_ROM = build_rom();

endpackage

// ----- rtl/tslfo_if.sv -----
// Valid/ready channel interfaces for the input and result beats of the LFO sweep.
interface tslfo_in_if;
    logic                           valid;
    logic                           ready;
    logic [tslfo_pkg::VALUE_W-1:0]  base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

interface tslfo_out_if;
    logic                           valid;
    logic                           ready;
    logic [tslfo_pkg::VALUE_W-1:0]  sweep_value;
    logic [15:0]                    phase_out;

    modport source (output valid, output sweep_value, output phase_out, input ready);
    modport sink   (input valid, input sweep_value, input phase_out, output ready);
endinterface

// ----- rtl/tslfo_front.sv -----
// Front end: configuration registers, increment divider, phase accumulator and beat classification.
module tslfo_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tslfo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tslfo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tslfo_pkg::VALUE_W-1:0]       i_base,
    output logic                                o_push,
    output tslfo_pkg::t_entry                   o_entry,
    input  logic                                i_full
);
    import tslfo_pkg::*;

    logic signed [STEP_W-1:0] r_step;
    logic [TPB_W-1:0]         r_tpb;
    logic                     r_start;
    logic                     r_busy;
    logic [CNT_W-1:0]         r_cnt;
    logic [TPB_W-1:0]         r_rem;
    logic [PHASE_BITS-1:0]    r_inc;
    logic [PHASE_BITS-1:0]    r_phase;

    logic [MAG_W-1:0]         mag;
    logic [1:0]               dir;
    logic [CNT_W-1:0]         exp_bit;
    logic [TPB_W:0]           shifted;
    logic                     qbit;
    logic                     accept;
    logic [PHASE_BITS-1:0]    n_phase;

    always_comb begin
        if (r_step > STEP_W'(MAX_STEP)) begin
            mag = MAG_W'(MAX_STEP);
            dir = DIR_UP;
        end else if (r_step < -STEP_W'(MAX_STEP)) begin
            mag = MAG_W'(MAX_STEP);
            dir = DIR_DOWN;
        end else if (r_step < 0) begin
            mag = MAG_W'(-r_step);
            dir = DIR_DOWN;
        end else begin
            mag = MAG_W'(r_step);
            dir = (r_step == 0) ? DIR_HOLD : DIR_UP;
        end
    end

    assign exp_bit = CNT_W'(PHASE_BITS - 6) + CNT_W'(mag);
    assign shifted = {r_rem, (r_cnt == exp_bit)};
    assign qbit    = (shifted >= {1'b0, r_tpb});

    assign o_ready = !r_start && !r_busy && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        unique case (dir)
            DIR_UP:   n_phase = r_phase + r_inc;
            DIR_DOWN: n_phase = r_phase - r_inc;
            default:  n_phase = r_phase;
        endcase
    end

    assign o_push        = accept;
    assign o_entry.base  = i_base;
    assign o_entry.idx   = n_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign o_entry.phase = n_phase[PHASE_BITS-1 -: 16];
    assign o_entry.dir   = dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_tpb   <= TPB_W'(96);
            r_start <= 1'b0;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_inc   <= '0;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RATE_STEP: begin
                        r_step  <= i_cfg_data[STEP_W-1:0];
                        r_start <= 1'b1;
                    end
                    REG_TICKS_PER_BAR: begin
                        r_tpb   <= i_cfg_data[TPB_W-1:0];
                        r_start <= 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_start) begin
                r_start <= 1'b0;
                r_rem   <= '0;
                r_inc   <= '0;
                r_cnt   <= CNT_W'(NUM_W - 1);
                r_busy  <= (mag != '0) && (r_tpb != '0);
            end else if (r_busy) begin
                r_rem <= qbit ? TPB_W'(shifted - {1'b0, r_tpb}) : shifted[TPB_W-1:0];
                r_inc <= {r_inc[PHASE_BITS-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

// ----- rtl/tslfo_queue.sv -----
// Short queue of classified beats between the front end and the back end.
module tslfo_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tslfo_pkg::t_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output tslfo_pkg::t_entry o_entry
);
    import tslfo_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PTR_W + 1)'(i_push) - (PTR_W + 1)'(do_pop);
        end
    end

endmodule

// ----- rtl/tslfo_back.sv -----
// Back end: travel table lookup, scaling multiply and the output register.
module tslfo_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  tslfo_pkg::t_entry             i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tslfo_pkg::VALUE_W-1:0] o_sweep,
    output logic [15:0]                   o_phase
);
    import tslfo_pkg::*;

    logic                 r_v1;
    t_travel              r_t1;
    logic [VALUE_W-1:0]   r_a1;
    logic [VALUE_W-1:0]   r_base1;
    logic [15:0]          r_phase1;
    logic [1:0]           r_dir1;
    logic                 r_v2;
    logic [VALUE_W-1:0]   r_sweep2;
    logic [15:0]          r_phase2;

    logic                 rdy2;
    logic                 rdy1;
    logic [VALUE_W+TRAVEL_W:0] prod;
    logic [VALUE_W-1:0]   adj;
    logic [VALUE_W-1:0]   n_sweep;

    assign rdy2  = !r_v2 || i_ready;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_valid && rdy1;

    assign prod = (VALUE_W + TRAVEL_W + 1)'(r_a1) * (VALUE_W + TRAVEL_W + 1)'(r_t1)
                + (VALUE_W + TRAVEL_W + 1)'(32768);
    assign adj  = prod[VALUE_W+15:16];

    always_comb begin
        unique case (r_dir1)
            DIR_UP:   n_sweep = r_base1 + adj;
            DIR_DOWN: n_sweep = r_base1 - adj;
            default:  n_sweep = r_base1;
        endcase
    end

    assign o_valid = r_v2;
    assign o_sweep = r_sweep2;
    assign o_phase = r_phase2;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_t1     <= TRAVEL_ROM[i_entry.idx];
            r_a1     <= (i_entry.dir == DIR_UP) ? ~i_entry.base : i_entry.base;
            r_base1  <= i_entry.base;
            r_phase1 <= i_entry.phase;
            r_dir1   <= i_entry.dir;
        end
        if (rdy2) begin
            r_sweep2 <= n_sweep;
            r_phase2 <= r_phase1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

endmodule

// ----- rtl/tempo_synced_lfo_sweep_top.sv -----
// Top level of the tempo-synced LFO sweep.
// A beat accepted at the input passes the queue, the lookup stage and the output register.
// One beat per cycle, but for output stalls and the divider run after a configuration write.
// The divider is a restoring unit that works out one quotient bit per cycle.
// Reset (synchronous, active low) clears phase, queue and pipeline, sets rate step 0 and
// ticks per bar 96, with a zero increment.
module tempo_synced_lfo_sweep_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tslfo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tslfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tslfo_in_if.sink                         i_lfo_in,
    tslfo_out_if.source                      o_lfo_out
);
    import tslfo_pkg::*;

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry pop_entry;

    tslfo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_lfo_in.valid),
        .o_ready    (i_lfo_in.ready),
        .i_base     (i_lfo_in.base_value),
        .o_push     (push),
        .o_entry    (push_entry),
        .i_full     (full)
    );

    tslfo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (pop_entry)
    );

    tslfo_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_entry (pop_entry),
        .o_valid (o_lfo_out.valid),
        .i_ready (o_lfo_out.ready),
        .o_sweep (o_lfo_out.sweep_value),
        .o_phase (o_lfo_out.phase_out)
    );

endmodule

// ----- test/tslfo_sweep_checker.sv -----
// Checker that predicts every sweep beat of the LFO and compares it with the block's output.
`timescale 1ns / 100ps
module tslfo_sweep_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tslfo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tslfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [tslfo_pkg::VALUE_W-1:0]    i_base_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [tslfo_pkg::VALUE_W-1:0]    i_sweep_value,
    input  logic [15:0]                      i_phase_out,
    input  logic                             i_drain_check,
    output int                               o_pending,
    output int                               o_fail_count
);
    import tslfo_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] sweep_value;
        logic [15:0]        phase_out;
    } t_sweep;

    logic [16:0]              cos_rom [TABLE_N];
    logic signed [STEP_W-1:0] rate_step;
    logic [TPB_W-1:0]         ticks_per_bar;
    logic [PHASE_BITS-1:0]    lfo_phase;
    logic [PHASE_BITS-1:0]    phase_inc;
    t_sweep                   pending_sweeps [$];
    int                       beat_count;
    bit                       drained;

    function automatic logic [16:0] raised_cos_entry(int unsigned idx);
        longint unsigned folded;
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint unsigned sq;
        longint          acc;
        folded = (idx > TABLE_N / 2) ? TABLE_N - idx : idx;
        angle = (PI_Q30 * folded) >> TABLE_BITS;
        angle_sq = (angle * angle) >> 30;
        term = angle;
        acc = longint'(angle);
        for (int k = 1; k <= 7; k++) begin
            term = (term * angle_sq) >> 30;
            term = term / (2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (longint'(1) << 30)) begin
            acc = longint'(1) << 30;
        end
        sq = unsigned'(acc) * unsigned'(acc);
        sq = (sq + (64'd1 << 43)) >> 44;
        return 17'(sq);
    endfunction

    function automatic int clamped_step(logic signed [STEP_W-1:0] s);
        int v;
        v = s;
        if (v > MAX_STEP) begin
            v = MAX_STEP;
        end
        if (v < -MAX_STEP) begin
            v = -MAX_STEP;
        end
        return v;
    endfunction

    function automatic logic [PHASE_BITS-1:0] derive_inc(logic signed [STEP_W-1:0] s,
                                                        logic [TPB_W-1:0] tpb);
        int          mag;
        logic [63:0] num;
        mag = clamped_step(s);
        if (mag < 0) begin
            mag = -mag;
        end
        if (mag == 0 || tpb == '0) begin
            return '0;
        end
        num = 64'd1 << (PHASE_BITS - 6 + mag);
        num = num / 64'(tpb);
        return num[PHASE_BITS-1:0];
    endfunction

    function automatic t_sweep advance_and_sweep(logic [VALUE_W-1:0] base);
        int          s;
        logic [1:0]  dir;
        logic [16:0] travel;
        logic [63:0] moved;
        t_sweep      r;
        s = clamped_step(rate_step);
        dir = (s > 0) ? DIR_UP : ((s < 0) ? DIR_DOWN : DIR_HOLD);
        if (dir == DIR_UP) begin
            lfo_phase = lfo_phase + phase_inc;
        end else if (dir == DIR_DOWN) begin
            lfo_phase = lfo_phase - phase_inc;
        end
        travel = cos_rom[lfo_phase[PHASE_BITS-1 -: TABLE_BITS]];
        r.sweep_value = base;
        if (dir == DIR_UP) begin
            moved = (64'(16'hFFFF - base) * 64'(travel) + 64'd32768) >> 16;
            r.sweep_value = base + moved[15:0];
        end else if (dir == DIR_DOWN) begin
            moved = (64'(base) * 64'(travel) + 64'd32768) >> 16;
            r.sweep_value = base - moved[15:0];
        end
        r.phase_out = lfo_phase[PHASE_BITS-1 -: 16];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] sweep beat %0d: %s is %h, expected %h", $time, beat_count, what, got,
                 want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        beat_count = 0;
        drained = 1'b0;
        for (int i = 0; i < TABLE_N; i++) begin
            cos_rom[i] = raised_cos_entry(i);
        end
    end

    always @(posedge i_clk) begin
        t_sweep want;
        if (!i_rst_n) begin
            rate_step = '0;
            ticks_per_bar = 16'd96;
            lfo_phase = '0;
            phase_inc = derive_inc(rate_step, ticks_per_bar);
            pending_sweeps.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RATE_STEP: begin
                        rate_step = i_cfg_data[STEP_W-1:0];
                    end
                    REG_TICKS_PER_BAR: begin
                        ticks_per_bar = i_cfg_data[TPB_W-1:0];
                    end
                    default: begin
                    end
                endcase
                phase_inc = derive_inc(rate_step, ticks_per_bar);
            end
            if (i_in_valid && i_in_ready) begin
                pending_sweeps.push_back(advance_and_sweep(i_base_value));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_sweeps.size() == 0) begin
                    report_mismatch("unexpected beat, sweep_value", i_sweep_value, '0);
                end else begin
                    want = pending_sweeps.pop_front();
                    if (i_sweep_value !== want.sweep_value) begin
                        report_mismatch("sweep_value", i_sweep_value, want.sweep_value);
                    end
                    if (i_phase_out !== want.phase_out) begin
                        report_mismatch("phase_out", i_phase_out, want.phase_out);
                    end
                end
                beat_count++;
            end
            if (i_drain_check && !drained) begin
                drained = 1'b1;
                while (pending_sweeps.size() > 0) begin
                    want = pending_sweeps.pop_front();
                    report_mismatch("undelivered beat, sweep_value", '0, want.sweep_value);
                end
            end
        end
        o_pending <= pending_sweeps.size();
    end

endmodule

// ----- test/tb_tempo_synced_lfo_sweep_top.sv -----
// Testbench top for the LFO sweep: directed and random configuration phases with random stalls.
`timescale 1ns / 100ps
module tb_tempo_synced_lfo_sweep_top;
    import tslfo_pkg::*;

    localparam int RANDOM_BEATS = 1950;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  drain_check;
    int                    pending;
    int                    fail_count;
    int                    cycle_count;
    bit                    calm;

    tslfo_in_if  lfo_in ();
    tslfo_out_if lfo_out ();

    tempo_synced_lfo_sweep_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_lfo_in   (lfo_in),
        .o_lfo_out  (lfo_out)
    );

    tslfo_sweep_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (lfo_in.valid),
        .i_in_ready    (lfo_in.ready),
        .i_base_value  (lfo_in.base_value),
        .i_out_valid   (lfo_out.valid),
        .i_out_ready   (lfo_out.ready),
        .i_sweep_value (lfo_out.sweep_value),
        .i_phase_out   (lfo_out.phase_out),
        .i_drain_check (drain_check),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_base();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [STEP_W-1:0] rand_step();
        int r;
        int mag;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r < 3) begin
            return STEP_W'($urandom);
        end
        mag = $urandom_range(1, MAX_STEP);
        return $urandom_range(0, 1) ? STEP_W'(mag) : STEP_W'(-mag);
    endfunction

    function automatic logic [TPB_W-1:0] rand_ticks();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r < 3) begin
            return TPB_W'($urandom_range(1, 8));
        end
        if (r < 7) begin
            return TPB_W'($urandom_range(9, 1000));
        end
        return TPB_W'($urandom);
    endfunction

    initial begin
        int stall;
        stall = 0;
        lfo_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                lfo_out.ready <= 1'b0;
            end else begin
                lfo_out.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_beat(logic [VALUE_W-1:0] base);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            lfo_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        lfo_in.valid <= 1'b1;
        lfo_in.base_value <= base;
        @(posedge i_clk);
        while (!lfo_in.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        lfo_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [STEP_W-1:0] step, logic [TPB_W-1:0] ticks, bit do_step,
                             bit do_ticks);
        logic [CFG_DATA_W-1:0] step_word;
        wait_idle();
        step_word = {(CFG_DATA_W - STEP_W)'($urandom), step};
        if (do_ticks && $urandom_range(0, 1)) begin
            write_reg(REG_TICKS_PER_BAR, ticks);
            if (do_step) begin
                write_reg(REG_RATE_STEP, step_word);
            end
        end else begin
            if (do_step) begin
                write_reg(REG_RATE_STEP, step_word);
            end
            if (do_ticks) begin
                write_reg(REG_TICKS_PER_BAR, ticks);
            end
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int random_left;
        int n;
        int which;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        drain_check <= 1'b0;
        lfo_in.valid <= 1'b0;
        lfo_in.base_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset step of zero the phase holds and the base passes straight through.
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        send_beat(16'h5555);
        send_beat(16'hAAAA);
        // Half a cycle per tick reaches full travel, which must land on the target exactly.
        configure(STEP_W'(6), 16'd2, 1'b1, 1'b1);
        send_beat(16'h0000);
        send_beat(16'h8000);
        send_beat(16'hFFFF);
        send_beat(16'h1234);
        configure(STEP_W'(-6), 16'd2, 1'b1, 1'b0);
        send_beat(16'hFFFF);
        send_beat(16'h0000);
        send_beat(16'h7FFF);
        // An increment of whole cycles wraps away completely.
        configure(STEP_W'(MAX_STEP), 16'd1, 1'b1, 1'b1);
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        // Steps beyond the limit are clamped.
        configure(STEP_W'(15), 16'd3, 1'b1, 1'b1);
        send_beat(16'h0001);
        send_beat(16'hFFFE);
        send_beat(16'hC3A5);
        configure(STEP_W'(-16), 16'hFFFF, 1'b1, 1'b1);
        send_beat(16'h3C5A);
        send_beat(16'hFFFF);
        // Zero ticks per bar holds the phase but the sweep still applies.
        configure(STEP_W'(3), 16'd0, 1'b1, 1'b1);
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        send_beat(16'h9001);
        configure(STEP_W'(0), 16'd24, 1'b1, 1'b1);
        send_beat(16'h4321);
        send_beat(16'hFFFF);

        random_left = RANDOM_BEATS;
        while (random_left > 0) begin
            which = $urandom_range(0, 4);
            configure(rand_step(), rand_ticks(), which != 1, which != 0);
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(15, 90);
            if (n > random_left) begin
                n = random_left;
            end
            repeat (n) send_beat(rand_base());
            random_left -= n;
        end
        calm = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        drain_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
